>>> rtl/core/hlew_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlew_pkg
// Shared widths, codes and controller/datapath interface types of the HCP
// lattice exclusion walk.
// ----------------------------------------------------------------------------
package hlew_pkg;

  localparam int VOX_W         = 20;
  localparam int MOL_W         = 14;
  localparam int DIM_W         = 11;
  localparam int CNT_W         = 21;
  localparam int RC_W          = 2 * DIM_W;
  localparam int DIR_W         = 4;
  localparam int ST_W          = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = CNT_W;
  localparam int OFF_W         = RC_W + 3;

  localparam int MAX_VOXELS    = 1 << VOX_W;
  localparam int MAX_MOLECULES = 1 << MOL_W;
  localparam int NEIGHBOURS    = 12;

  localparam int OCC_WORD_W    = 32;
  localparam int OCC_BIT_W     = $clog2(OCC_WORD_W);
  localparam int OCC_DEPTH     = MAX_VOXELS / OCC_WORD_W;
  localparam int OCC_ADDR_W    = $clog2(OCC_DEPTH);

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OCCUPIED = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 2'd2;

  // voxel source for occupancy reads and the result
  localparam logic [1:0] VSEL_PV   = 2'd0;
  localparam logic [1:0] VSEL_CURR = 2'd1;
  localparam logic [1:0] VSEL_TAR  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_N0  = 4'd0;
  localparam logic [DIR_W-1:0] DIR_N1  = 4'd1;
  localparam logic [DIR_W-1:0] DIR_N2  = 4'd2;
  localparam logic [DIR_W-1:0] DIR_N3  = 4'd3;
  localparam logic [DIR_W-1:0] DIR_N4  = 4'd4;
  localparam logic [DIR_W-1:0] DIR_N5  = 4'd5;
  localparam logic [DIR_W-1:0] DIR_N6  = 4'd6;
  localparam logic [DIR_W-1:0] DIR_N7  = 4'd7;
  localparam logic [DIR_W-1:0] DIR_N8  = 4'd8;
  localparam logic [DIR_W-1:0] DIR_N9  = 4'd9;
  localparam logic [DIR_W-1:0] DIR_N10 = 4'd10;
  localparam logic [DIR_W-1:0] DIR_N11 = 4'd11;

  typedef struct packed {
    logic            latch;
    logic            occ_rd;
    logic [1:0]      occ_sel;
    logic            occ_wr;
    logic            occ_val;
    logic            clr_wr;
    logic            pos_rd;
    logic            pos_wr;
    logic            cur_ld;
    logic            div1_go;
    logic            div2_go;
    logic            lp_ld;
    logic            cp_ld;
    logic            off_ld;
    logic            tar_ld;
    logic            out_fire;
    logic [ST_W-1:0] out_st;
    logic [1:0]      out_vsel;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic pv_oor;
    logic occ_bit;
    logic tar_oor;
    logic tar_same;
    logic div_done;
    logic clr_last;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/hlew_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlew_div
// Restoring divider, one quotient bit per cycle, for the layer and column
// parity of a voxel index.
// ----------------------------------------------------------------------------
module hlew_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [hlew_pkg::VOX_W-1:0] dividend,
  input  wire logic [hlew_pkg::RC_W-1:0]  divisor,
  output logic                           done,
  output logic [hlew_pkg::VOX_W-1:0]      quot,
  output logic [hlew_pkg::RC_W-1:0]       rem
);
  import hlew_pkg::*;

  localparam int CNT_BITS = $clog2(VOX_W + 1);

  logic [CNT_BITS-1:0] cnt_r;
  logic                done_r;
  logic [VOX_W-1:0]    dvd_r;
  logic [RC_W-1:0]     rem_r;
  logic [RC_W-1:0]     div_r;
  logic [RC_W:0]       trial;
  logic [RC_W:0]       diff;
  logic                ge;
  logic [RC_W-1:0]     rem_nxt;

  assign trial   = {rem_r, dvd_r[VOX_W-1]};
  assign ge      = trial >= {1'b0, div_r};
  assign diff    = trial - {1'b0, div_r};
  assign rem_nxt = ge ? diff[RC_W-1:0] : trial[RC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_BITS'(VOX_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[VOX_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/core/hlew_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlew_dp
// Datapath: configuration, occupancy and position memories, neighbour
// arithmetic and the result register.
// ----------------------------------------------------------------------------
module hlew_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hlew_pkg::dp_cmd_t             cmd,
  output hlew_pkg::dp_sts_t                  sts,
  input  wire logic                          cfg_we,
  input  wire logic [hlew_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hlew_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_kind,
  input  wire logic [hlew_pkg::MOL_W-1:0]     in_molecule,
  input  wire logic [hlew_pkg::DIR_W-1:0]     in_direction,
  input  wire logic [hlew_pkg::VOX_W-1:0]     in_place_voxel,
  output logic                               out_strobe,
  output logic [hlew_pkg::MOL_W-1:0]          out_molecule_out,
  output logic [hlew_pkg::VOX_W-1:0]          out_voxel_out,
  output logic [hlew_pkg::ST_W-1:0]           out_status
);
  import hlew_pkg::*;

  logic [DIM_W-1:0]      rows_r, cols_r;
  logic [CNT_W-1:0]      vcount_r;
  logic [RC_W-1:0]       rc_r;
  logic [DIM_W-1:0]      r_eff, c_eff;
  logic [CNT_W-1:0]      nv;

  logic                  kind_r;
  logic [MOL_W-1:0]      mol_r;
  logic [DIR_W-1:0]      dir_r;
  logic [VOX_W-1:0]      pv_r;
  logic [VOX_W-1:0]      curr_r;
  logic                  lp_r, cp_r;
  logic signed [OFF_W-1:0] off_r, off_nxt, tar_r;
  logic [VOX_W-1:0]      tar_vox;

  logic [OCC_WORD_W-1:0] occ_mem [OCC_DEPTH];
  logic [OCC_WORD_W-1:0] occ_q_r;
  logic [VOX_W-1:0]      occ_addr_r;
  logic [VOX_W-1:0]      occ_raddr;
  logic [OCC_WORD_W-1:0] occ_wdata;
  logic [OCC_ADDR_W-1:0] clr_idx_r;

  logic [VOX_W-1:0]      pos_mem [MAX_MOLECULES];
  logic [VOX_W-1:0]      pos_q_r;

  logic                  div_go, div_done;
  logic [VOX_W-1:0]      div_dvd, div_quot;
  logic [RC_W-1:0]       div_dsr, div_rem;

  logic                  out_strobe_r;
  logic [MOL_W-1:0]      out_mol_r;
  logic [VOX_W-1:0]      out_vox_r;
  logic [ST_W-1:0]       out_st_r;

  assign r_eff = (rows_r == '0) ? DIM_W'(1) : rows_r;
  assign c_eff = (cols_r == '0) ? DIM_W'(1) : cols_r;
  assign nv    = (vcount_r > CNT_W'(MAX_VOXELS)) ? CNT_W'(MAX_VOXELS) : vcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DIM_W'(64);
      cols_r   <= DIM_W'(64);
      vcount_r <= CNT_W'(MAX_VOXELS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS:   rows_r   <= cfg_wdata[DIM_W-1:0];
        CFG_COLS:   cols_r   <= cfg_wdata[DIM_W-1:0];
        CFG_VCOUNT: vcount_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rc_r <= RC_W'(r_eff) * RC_W'(c_eff);
  end

  // request capture and move working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      mol_r  <= in_molecule;
      dir_r  <= in_direction;
      pv_r   <= in_place_voxel;
    end
    if (cmd.cur_ld) curr_r <= pos_q_r;
    if (cmd.lp_ld)  lp_r   <= div_quot[0];
    if (cmd.cp_ld)  cp_r   <= div_quot[0];
    if (cmd.off_ld) off_r  <= off_nxt;
    if (cmd.tar_ld) tar_r  <= signed'(OFF_W'(curr_r)) + off_r;
  end

  // layer parity from curr / (rows*cols), then column parity from remainder / rows
  assign div_go  = cmd.div1_go | cmd.div2_go;
  assign div_dvd = cmd.div2_go ? div_rem[VOX_W-1:0] : curr_r;
  assign div_dsr = cmd.div2_go ? RC_W'(r_eff) : rc_r;

  hlew_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    logic signed [OFF_W-1:0] one, rs, rcs, cls, xs, cps, sl;
    one = OFF_W'(1);
    rs  = signed'(OFF_W'(r_eff));
    rcs = signed'(OFF_W'(rc_r));
    cls = signed'(OFF_W'(cp_r & lp_r));
    xs  = signed'(OFF_W'(cp_r ^ lp_r));
    cps = signed'(OFF_W'(cp_r));
    sl  = lp_r ? rs : '0;
    case (dir_r)
      DIR_N0:  off_nxt = -one;
      DIR_N1:  off_nxt = one;
      DIR_N2:  off_nxt = -rs - one + cls;
      DIR_N3:  off_nxt = -rs + cls;
      DIR_N4:  off_nxt = rs - one + xs;
      DIR_N5:  off_nxt = rs + xs;
      DIR_N6:  off_nxt = -rcs - rs + sl - cls;
      DIR_N7:  off_nxt = lp_r ? (-rcs + one) : (-rcs + cps - one);
      DIR_N8:  off_nxt = -rcs + (lp_r ? rs : cps);
      DIR_N9:  off_nxt = rcs - rs + sl - cls;
      DIR_N10: off_nxt = cp_r ? rcs : (lp_r ? (rcs + one) : (rcs - one));
      DIR_N11: off_nxt = rcs + (lp_r ? rs : cps);
      default: off_nxt = '0;
    endcase
  end

  assign tar_vox = tar_r[VOX_W-1:0];

  always_comb begin
    case (cmd.occ_sel)
      VSEL_PV:   occ_raddr = pv_r;
      VSEL_CURR: occ_raddr = curr_r;
      VSEL_TAR:  occ_raddr = tar_vox;
      default:   occ_raddr = pv_r;
    endcase
  end

  always_comb begin
    occ_wdata = occ_q_r;
    occ_wdata[occ_addr_r[OCC_BIT_W-1:0]] = cmd.occ_val;
  end

  // occupancy: one word per 32 voxels, read-modify-write
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      occ_mem[clr_idx_r] <= '0;
    end else if (cmd.occ_wr) begin
      occ_mem[occ_addr_r[VOX_W-1:OCC_BIT_W]] <= occ_wdata;
    end
    if (cmd.occ_rd) begin
      occ_q_r    <= occ_mem[occ_raddr[VOX_W-1:OCC_BIT_W]];
      occ_addr_r <= occ_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_wr) begin
      pos_mem[mol_r] <= kind_r ? tar_vox : pv_r;
    end
    if (cmd.pos_rd) begin
      pos_q_r <= pos_mem[mol_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_mol_r <= mol_r;
      out_st_r  <= cmd.out_st;
      case (cmd.out_vsel)
        VSEL_PV:   out_vox_r <= pv_r;
        VSEL_CURR: out_vox_r <= curr_r;
        VSEL_TAR:  out_vox_r <= tar_vox;
        default:   out_vox_r <= pv_r;
      endcase
    end
  end

  assign sts.kind     = kind_r;
  assign sts.pv_oor   = CNT_W'(pv_r) >= nv;
  assign sts.occ_bit  = occ_q_r[occ_addr_r[OCC_BIT_W-1:0]];
  assign sts.tar_oor  = tar_r[OFF_W-1] || (tar_r[OFF_W-2:0] >= (OFF_W-1)'(nv));
  assign sts.tar_same = tar_r == signed'(OFF_W'(curr_r));
  assign sts.div_done = div_done;
  assign sts.clr_last = &clr_idx_r;

  assign out_strobe       = out_strobe_r;
  assign out_molecule_out = out_mol_r;
  assign out_voxel_out    = out_vox_r;
  assign out_status       = out_st_r;

endmodule
`default_nettype wire

>>> rtl/core/hlew_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlew_ctrl
// Controller: clearing pass, place sequence and move sequence.
// ----------------------------------------------------------------------------
module hlew_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire hlew_pkg::dp_sts_t sts,
  output hlew_pkg::dp_cmd_t      cmd
);
  import hlew_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_P_RD  = 4'd2;
  localparam logic [3:0] S_P_CHK = 4'd3;
  localparam logic [3:0] S_M_RD  = 4'd4;
  localparam logic [3:0] S_M_CUR = 4'd5;
  localparam logic [3:0] S_M_D1S = 4'd6;
  localparam logic [3:0] S_M_D1  = 4'd7;
  localparam logic [3:0] S_M_D2  = 4'd8;
  localparam logic [3:0] S_M_OFF = 4'd9;
  localparam logic [3:0] S_M_TAR = 4'd10;
  localparam logic [3:0] S_M_CHK = 4'd11;
  localparam logic [3:0] S_M_OCC = 4'd12;
  localparam logic [3:0] S_M_CRD = 4'd13;
  localparam logic [3:0] S_M_CWR = 4'd14;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.occ_sel  = VSEL_PV;
    cmd.out_vsel = VSEL_PV;
    cmd.out_st   = ST_OK;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        if (sts.kind) begin
          cmd.pos_rd = 1'b1;
          state_nxt  = S_M_CUR;
        end else begin
          cmd.occ_rd  = 1'b1;
          cmd.occ_sel = VSEL_PV;
          state_nxt   = S_P_CHK;
        end
      end
      S_P_CHK: begin
        cmd.out_fire = 1'b1;
        cmd.out_vsel = VSEL_PV;
        state_nxt    = S_IDLE;
        if (sts.pv_oor) begin
          cmd.out_st = ST_OUTSIDE;
        end else if (sts.occ_bit) begin
          cmd.out_st = ST_OCCUPIED;
        end else begin
          cmd.out_st  = ST_OK;
          cmd.occ_wr  = 1'b1;
          cmd.occ_val = 1'b1;
          cmd.pos_wr  = 1'b1;
        end
      end
      S_M_RD: begin
        cmd.pos_rd = 1'b1;
        state_nxt  = S_M_CUR;
      end
      S_M_CUR: begin
        cmd.cur_ld = 1'b1;
        state_nxt  = S_M_D1S;
      end
      S_M_D1S: begin
        cmd.div1_go = 1'b1;
        state_nxt   = S_M_D1;
      end
      S_M_D1: begin
        // chain the column division off the layer remainder
        if (sts.div_done) begin
          cmd.lp_ld   = 1'b1;
          cmd.div2_go = 1'b1;
          state_nxt   = S_M_D2;
        end
      end
      S_M_D2: begin
        if (sts.div_done) begin
          cmd.cp_ld = 1'b1;
          state_nxt = S_M_OFF;
        end
      end
      S_M_OFF: begin
        cmd.off_ld = 1'b1;
        state_nxt  = S_M_TAR;
      end
      S_M_TAR: begin
        cmd.tar_ld = 1'b1;
        state_nxt  = S_M_CHK;
      end
      S_M_CHK: begin
        cmd.out_vsel = VSEL_CURR;
        if (sts.tar_oor) begin
          cmd.out_fire = 1'b1;
          cmd.out_st   = ST_OUTSIDE;
          state_nxt    = S_IDLE;
        end else if (sts.tar_same) begin
          cmd.out_fire = 1'b1;
          cmd.out_st   = ST_OCCUPIED;
          state_nxt    = S_IDLE;
        end else begin
          cmd.occ_rd  = 1'b1;
          cmd.occ_sel = VSEL_TAR;
          state_nxt   = S_M_OCC;
        end
      end
      S_M_OCC: begin
        if (sts.occ_bit) begin
          cmd.out_fire = 1'b1;
          cmd.out_st   = ST_OCCUPIED;
          cmd.out_vsel = VSEL_CURR;
          state_nxt    = S_IDLE;
        end else begin
          cmd.occ_wr  = 1'b1;
          cmd.occ_val = 1'b1;
          state_nxt   = S_M_CRD;
        end
      end
      S_M_CRD: begin
        // reread after the set so a shared word keeps the new bit
        cmd.occ_rd  = 1'b1;
        cmd.occ_sel = VSEL_CURR;
        state_nxt   = S_M_CWR;
      end
      S_M_CWR: begin
        cmd.occ_wr   = 1'b1;
        cmd.occ_val  = 1'b0;
        cmd.pos_wr   = 1'b1;
        cmd.out_fire = 1'b1;
        cmd.out_st   = ST_OK;
        cmd.out_vsel = VSEL_TAR;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/hcp_lattice_exclusion_walk.sv
`default_nettype none
// Sequence: a place request reads and checks the occupancy word of its voxel,
// then strobes its result. A move reads its position, runs two bit-serial
// divisions of the voxel index, and answers outside or own-voxel targets first,
// then occupied ones, then completed moves. Flow: one request at a time; the
// next is accepted at the edge that takes the result.
// Reset: occupancy cleared one 32-voxel word per cycle, busy high until done.
// ----------------------------------------------------------------------------
// hcp_lattice_exclusion_walk
// Random walk with exclusion on an HCP voxel lattice: place and move requests.
// ----------------------------------------------------------------------------
module hcp_lattice_exclusion_walk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hlew_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hlew_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [hlew_pkg::MOL_W-1:0]     in_molecule,
  input  wire logic [hlew_pkg::DIR_W-1:0]     in_direction,
  input  wire logic [hlew_pkg::VOX_W-1:0]     in_place_voxel,
  output logic                               out_strobe,
  output logic [hlew_pkg::MOL_W-1:0]          out_molecule_out,
  output logic [hlew_pkg::VOX_W-1:0]          out_voxel_out,
  output logic [hlew_pkg::ST_W-1:0]           out_status
);
  import hlew_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hlew_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hlew_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_kind),
    .in_molecule      (in_molecule),
    .in_direction     (in_direction),
    .in_place_voxel   (in_place_voxel),
    .out_strobe       (out_strobe),
    .out_molecule_out (out_molecule_out),
    .out_voxel_out    (out_voxel_out),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

>>> tb/sv/hcp_lattice_exclusion_walk_test.sv
// ----------------------------------------------------------------------------
// hcp_lattice_exclusion_walk_test
// Self-checking bench for the HCP lattice exclusion walk. A directed table
// covers the lattice edges, unused directions and repeat placement. Random
// place and move requests then run over several lattice shapes. Each result
// is checked against its table row or an in-bench occupancy and position model.
// ----------------------------------------------------------------------------
module hcp_lattice_exclusion_walk_test;
  import hlew_pkg::*;

  localparam int WDOG_LIMIT = 200000;
  localparam int TAIL_WAIT  = 100;

  typedef struct {
    logic [MOL_W-1:0] mol;
    logic [VOX_W-1:0] vox;
    logic [ST_W-1:0]  st;
  } walk_res_t;

  typedef struct {
    logic             kind;
    logic [MOL_W-1:0] mol;
    logic [DIR_W-1:0] dir;
    logic [VOX_W-1:0] pv;
    bit               typed;
    logic [VOX_W-1:0] vox;
    logic [ST_W-1:0]  st;
  } walk_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic [MOL_W-1:0] in_molecule = '0;
  logic [DIR_W-1:0] in_direction = '0;
  logic [VOX_W-1:0] in_place_voxel = '0;
  logic out_strobe;
  logic [MOL_W-1:0] out_molecule_out;
  logic [VOX_W-1:0] out_voxel_out;
  logic [ST_W-1:0] out_status;

  hcp_lattice_exclusion_walk dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy,
    .in_kind, .in_molecule, .in_direction, .in_place_voxel,
    .out_strobe, .out_molecule_out, .out_voxel_out, .out_status
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  bit occ_map [MAX_VOXELS];
  logic [VOX_W-1:0] mol_pos [MAX_MOLECULES];
  bit mol_placed [MAX_MOLECULES];
  logic [DIM_W-1:0] lat_rows = 64;
  logic [DIM_W-1:0] lat_cols = 64;
  logic [CNT_W-1:0] lat_count = 21'd1048576;

  walk_res_t pending_results [$];
  logic [MOL_W-1:0] phase_mols [$];
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic longint hcp_offset(longint curr, int dir, longint r, longint c);
    longint rc, cp, lp, x;
    rc = r * c;
    cp = ((curr % rc) / r) & 1;
    lp = (curr / rc) & 1;
    x  = cp ^ lp;
    case (dir)
      0:  return -1;
      1:  return 1;
      2:  return -r - 1 + cp * lp;
      3:  return -r + cp * lp;
      4:  return r - 1 + x;
      5:  return r + x;
      6:  return -rc - r + r * lp - cp * lp;
      7:  return -rc + lp + (1 - lp) * (cp - 1);
      8:  return -rc + r * lp + (1 - lp) * cp;
      9:  return rc - r + lp * r - cp * lp;
      10: return rc + (1 - cp) * (2 * lp - 1);
      11: return rc + r * lp + (1 - lp) * cp;
      default: return 0;
    endcase
  endfunction

  function automatic longint voxels_in_use();
    return (lat_count > MAX_VOXELS) ? MAX_VOXELS : lat_count;
  endfunction

  function automatic walk_res_t walk_step(logic kind, logic [MOL_W-1:0] mol,
                                          logic [DIR_W-1:0] dir, logic [VOX_W-1:0] pv);
    walk_res_t res;
    longint nv, r, c, curr, tar;
    nv = voxels_in_use();
    res.mol = mol;
    if (kind == 1'b0) begin
      res.vox = pv;
      if (pv >= nv) res.st = ST_OUTSIDE;
      else if (occ_map[pv]) res.st = ST_OCCUPIED;
      else begin
        occ_map[pv] = 1'b1;
        mol_pos[mol] = pv;
        mol_placed[mol] = 1'b1;
        res.st = ST_OK;
      end
    end else begin
      r = (lat_rows == 0) ? 1 : lat_rows;
      c = (lat_cols == 0) ? 1 : lat_cols;
      curr = mol_pos[mol];
      tar = curr + hcp_offset(curr, dir, r, c);
      res.vox = VOX_W'(curr);
      if (tar < 0 || tar >= nv) res.st = ST_OUTSIDE;
      else if (tar == curr || occ_map[tar]) res.st = ST_OCCUPIED;
      else begin
        occ_map[tar] = 1'b1;
        occ_map[curr] = 1'b0;
        mol_pos[mol] = VOX_W'(tar);
        res.vox = VOX_W'(tar);
        res.st = ST_OK;
      end
    end
    return res;
  endfunction

  // compare each strobed result with the oldest pending one
  always @(posedge clk) begin
    walk_res_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result mol=%0d vox=%0d st=%0d",
                   out_molecule_out, out_voxel_out, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_molecule_out !== want.mol || out_voxel_out !== want.vox ||
            out_status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mol=%0d vox=%0d st=%0d, got mol=%0d vox=%0d st=%0d",
                     want.mol, want.vox, want.st,
                     out_molecule_out, out_voxel_out, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // drive one request and hold it until accepted; leaves start high
  task automatic send_request(walk_row_t row);
    walk_res_t res;
    in_kind <= row.kind;
    in_molecule <= row.mol;
    in_direction <= row.dir;
    in_place_voxel <= row.pv;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    res = walk_step(row.kind, row.mol, row.dir, row.pv);
    if (row.typed) begin
      res.vox = row.vox;
      res.st = row.st;
    end
    pending_results.push_back(res);
  endtask

  task automatic random_gap();
    int pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 50) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic set_lattice(int r, int c, int n);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_wdata <= CFG_W'(r);
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_wdata <= CFG_W'(c);
    @(posedge clk);
    cfg_index <= CFG_VCOUNT;
    cfg_wdata <= CFG_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    lat_rows = DIM_W'(r);
    lat_cols = DIM_W'(c);
    lat_count = CNT_W'(n);
  endtask

  task automatic random_phase(int r, int c, int n, int items, int pool);
    walk_row_t row;
    longint nv;
    int base, pick;
    drain();
    set_lattice(r, c, n);
    nv = voxels_in_use();
    phase_mols.delete();
    base = $urandom_range(0, MAX_MOLECULES - pool);
    for (int i = 0; i < items; i++) begin
      row.typed = 1'b0;
      row.dir = ($urandom_range(0, 9) == 0) ? DIR_W'($urandom_range(12, 15))
                                             : DIR_W'($urandom_range(0, 11));
      pick = $urandom_range(0, 99);
      if (phase_mols.size() == 0 || pick < 35) begin
        row.kind = 1'b0;
        row.mol = (pick < 5) ? MOL_W'($urandom_range(0, MAX_MOLECULES - 1))
                             : MOL_W'(base + $urandom_range(0, pool - 1));
        if (pick < 10 && nv < MAX_VOXELS)
          row.pv = VOX_W'($urandom_range(nv, MAX_VOXELS - 1));
        else if (pick < 15) row.pv = VOX_W'($urandom_range(0, MAX_VOXELS - 1));
        else row.pv = VOX_W'($urandom_range(0, nv - 1));
        if (row.pv < nv) phase_mols.push_back(row.mol);
      end else begin
        row.kind = 1'b1;
        row.mol = phase_mols[$urandom_range(0, phase_mols.size() - 1)];
        row.pv = VOX_W'($urandom_range(0, MAX_VOXELS - 1));
      end
      // only move molecules whose position is known
      if (row.kind == 1'b1 && !mol_placed[row.mol]) row.kind = 1'b0;
      send_request(row);
      random_gap();
    end
  endtask

  walk_row_t dir_table [$] = '{
    '{1'b0, 14'd0,     4'd0,  20'd0,       1'b1, 20'd0,       ST_OK},
    '{1'b0, 14'd1,     4'd0,  20'd0,       1'b1, 20'd0,       ST_OCCUPIED},
    '{1'b0, 14'd16383, 4'd15, 20'd1048575, 1'b1, 20'd1048575, ST_OK},
    '{1'b1, 14'd0,     DIR_N0, 20'd0,      1'b1, 20'd0,       ST_OUTSIDE},
    '{1'b1, 14'd16383, DIR_N1, 20'd0,      1'b1, 20'd1048575, ST_OUTSIDE},
    '{1'b1, 14'd0,     4'd12, 20'd0,       1'b1, 20'd0,       ST_OCCUPIED},
    '{1'b1, 14'd0,     4'd15, 20'd0,       1'b1, 20'd0,       ST_OCCUPIED},
    '{1'b0, 14'd2,     4'd0,  20'd1,       1'b1, 20'd1,       ST_OK},
    '{1'b1, 14'd0,     DIR_N1, 20'd0,      1'b1, 20'd0,       ST_OCCUPIED},
    '{1'b0, 14'd3,     4'd0,  20'd4160,    1'b1, 20'd4160,    ST_OK},
    '{1'b1, 14'd3,     DIR_N2,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N3,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N4,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N5,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N6,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N7,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N8,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N9,  20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N10, 20'd0, 1'b0, 20'd0, ST_OK},
    '{1'b1, 14'd3,     DIR_N11, 20'd0, 1'b0, 20'd0, ST_OK},
    // placing again keeps the old voxel marked
    '{1'b0, 14'd0,     4'd0,  20'd300,     1'b1, 20'd300,     ST_OK},
    '{1'b0, 14'd5,     4'd0,  20'd0,       1'b1, 20'd0,       ST_OCCUPIED}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // hold off while the occupancy map is cleared
    while (busy) @(posedge clk);
    set_lattice(64, 64, 1048576);
    foreach (dir_table[i]) begin
      send_request(dir_table[i]);
      random_gap();
    end
    random_phase(4, 5, 80, 300, 24);
    random_phase(1, 1, 16, 150, 12);
    random_phase(0, 0, 10, 100, 8);
    random_phase(7, 3, 2097151, 200, 16383);
    random_phase(1024, 1024, 1048576, 200, 16383);
    random_phase(3, 4, 50, 200, 20);
    random_phase(16, 8, 1000, 250, 64);
    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
